FILE: sv/sensor_report_packet_parser_unit_macros.svh
// assertion macros for the sensor report packet parser
`ifndef SENSOR_REPORT_PACKET_PARSER_UNIT_MACROS_SVH
`define SENSOR_REPORT_PACKET_PARSER_UNIT_MACROS_SVH

// checked at every edge outside reset
`define SRPP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SRPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/srpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srpp_pkg;

   localparam int unsigned HEADER_BYTES        = 4;
   localparam int unsigned TIMESTAMP_BYTES     = 5;
   localparam int unsigned SENSOR_REPORT_BYTES = 10;
   localparam logic [7:0]  TIMESTAMP_ID        = 8'hFB;
   localparam int unsigned LENGTH_BITS         = 15;

   localparam logic [7:0]  OFF_X_LO = 8'd4;
   localparam logic [7:0]  OFF_X_HI = 8'd5;
   localparam logic [7:0]  OFF_Y_LO = 8'd6;
   localparam logic [7:0]  OFF_Y_HI = 8'd7;
   localparam logic [7:0]  OFF_Z_LO = 8'd8;
   localparam logic [7:0]  OFF_Z_HI = 8'd9;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_ACCEL = 2'd1,
      KIND_GYRO  = 2'd2,
      KIND_MAG   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_REPORTS_CHANNEL = 2'd0,
      CSR_ACCEL_ID        = 2'd1,
      CSR_GYRO_ID         = 2'd2,
      CSR_MAG_ID          = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] reports_channel;
      logic [7:0] accel_report_id;
      logic [7:0] gyro_report_id;
      logic [7:0] mag_report_id;
   } cfg_type;

   typedef struct packed {
      logic        any_report;
      logic        packet_end;
      logic [15:0] axis_z;
      logic [15:0] axis_y;
      logic [15:0] axis_x;
      kind_type    report_kind;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/srpp_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module srpp_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [3:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output srpp_pkg::cfg_type     cfg
);

   srpp_pkg::cfg_type       cfg_ff;
   srpp_pkg::cfg_type       cfg_in;
   srpp_pkg::csr_index_type sel;
   logic                    wr_en;
   logic [7:0]              rd_byte;

   assign sel        = srpp_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            srpp_pkg::CSR_REPORTS_CHANNEL: cfg_in.reports_channel = csr_pwdata[7:0];
            srpp_pkg::CSR_ACCEL_ID:        cfg_in.accel_report_id = csr_pwdata[7:0];
            srpp_pkg::CSR_GYRO_ID:         cfg_in.gyro_report_id  = csr_pwdata[7:0];
            srpp_pkg::CSR_MAG_ID:          cfg_in.mag_report_id   = csr_pwdata[7:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         srpp_pkg::CSR_REPORTS_CHANNEL: rd_byte = cfg_ff.reports_channel;
         srpp_pkg::CSR_ACCEL_ID:        rd_byte = cfg_ff.accel_report_id;
         srpp_pkg::CSR_GYRO_ID:         rd_byte = cfg_ff.gyro_report_id;
         srpp_pkg::CSR_MAG_ID:          rd_byte = cfg_ff.mag_report_id;
         default:                       rd_byte = 8'd0;
      endcase
   end

   assign csr_prdata = {24'd0, rd_byte};
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reports_channel <= 8'd3;
         cfg_ff.accel_report_id <= 8'd1;
         cfg_ff.gyro_report_id  <= 8'd2;
         cfg_ff.mag_report_id   <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/srpp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module srpp_core #(
   parameter int unsigned MAX_PACKET_BYTES = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire logic               first_byte,
   input  wire srpp_pkg::cfg_type  cfg,
   output logic                    res_vld,
   output srpp_pkg::result_type    res
);

   localparam logic [14:0] MAX_LEN15 = 15'(MAX_PACKET_BYTES);
   localparam logic [7:0]  MAX_LEN8  = 8'(MAX_PACKET_BYTES);

   logic [7:0]          byte_index_ff, byte_index_in;
   logic [7:0]          packet_length_ff, packet_length_in;
   logic [7:0]          report_start_ff, report_start_in;
   srpp_pkg::kind_type  current_kind_ff, current_kind_in;
   logic                parse_stopped_ff, parse_stopped_in;
   logic                updated_ff, updated_in;
   logic [7:0]          low_hold_ff, low_hold_in;
   logic [15:0]         x_hold_ff, x_hold_in;
   logic [15:0]         y_hold_ff, y_hold_in;

   logic [7:0]          b_idx, b_rs, b_plen, off, rs_ts, rs_sr, len_clamp;
   srpp_pkg::kind_type  b_ck, id_kind, kind_out;
   logic                b_upd, id_hit, no_fit, stop_id, pkt_end;
   logic [8:0]          ts_sum, sr_sum, idx_p1;
   logic [14:0]         len15;
   logic [15:0]         word;

   // a new packet restarts the walk
   assign b_idx  = first_byte ? 8'd0 : byte_index_ff;
   assign b_rs   = first_byte ? 8'(srpp_pkg::HEADER_BYTES) : report_start_ff;
   assign b_plen = first_byte ? 8'd0 : packet_length_ff;
   assign b_ck   = first_byte ? srpp_pkg::KIND_NONE : current_kind_ff;
   assign b_upd  = first_byte ? 1'b0 : updated_ff;

   assign len15     = {data_byte[6:0], low_hold_ff};
   assign len_clamp = (len15 > MAX_LEN15) ? MAX_LEN8 : len15[7:0];

   assign ts_sum = {1'b0, b_rs} + 9'(srpp_pkg::TIMESTAMP_BYTES);
   assign sr_sum = {1'b0, b_rs} + 9'(srpp_pkg::SENSOR_REPORT_BYTES);
   assign rs_ts  = ts_sum[8] ? 8'hFF : ts_sum[7:0];
   assign rs_sr  = sr_sum[8] ? 8'hFF : sr_sum[7:0];
   assign no_fit = sr_sum > {1'b0, b_plen};
   assign off    = b_idx - b_rs;
   assign idx_p1 = {1'b0, b_idx} + 9'd1;
   assign word   = {data_byte, low_hold_ff};

   // id priority: accel, then gyro, then mag
   always_comb begin
      id_hit  = 1'b1;
      id_kind = srpp_pkg::KIND_MAG;
      if (data_byte == cfg.accel_report_id) begin
         id_kind = srpp_pkg::KIND_ACCEL;
      end else if (data_byte == cfg.gyro_report_id) begin
         id_kind = srpp_pkg::KIND_GYRO;
      end else if (data_byte != cfg.mag_report_id) begin
         id_hit = 1'b0;
      end
   end

   always_comb begin
      byte_index_in    = byte_index_ff;
      packet_length_in = packet_length_ff;
      report_start_in  = report_start_ff;
      current_kind_in  = current_kind_ff;
      parse_stopped_in = parse_stopped_ff;
      updated_in       = updated_ff;
      low_hold_in      = low_hold_ff;
      x_hold_in        = x_hold_ff;
      y_hold_in        = y_hold_ff;
      res_vld          = 1'b0;
      res              = '0;
      kind_out         = srpp_pkg::KIND_NONE;
      stop_id          = 1'b0;
      pkt_end          = 1'b0;

      if (step && (first_byte || !parse_stopped_ff)) begin
         byte_index_in    = (b_idx == 8'hFF) ? b_idx : b_idx + 8'd1;
         packet_length_in = b_plen;
         report_start_in  = b_rs;
         current_kind_in  = b_ck;
         parse_stopped_in = 1'b0;
         updated_in       = b_upd;

         if (b_idx == 8'd0) begin
            low_hold_in = data_byte;
         end else if (b_idx == 8'd1) begin
            packet_length_in = len_clamp;
            if (len_clamp <= 8'(srpp_pkg::HEADER_BYTES)) begin
               parse_stopped_in = 1'b1;
               res_vld          = 1'b1;
               res.packet_end   = 1'b1;
            end
         end else if (b_idx == 8'd2) begin
            if (data_byte != cfg.reports_channel) begin
               parse_stopped_in = 1'b1;
               res_vld          = 1'b1;
               res.packet_end   = 1'b1;
            end
         end else if (b_idx != 8'd3) begin
            if (b_idx == b_rs) begin
               current_kind_in = srpp_pkg::KIND_NONE;
               if (data_byte == srpp_pkg::TIMESTAMP_ID) begin
                  report_start_in = rs_ts;
               end else if (id_hit) begin
                  if (no_fit) begin
                     stop_id = 1'b1;
                  end else begin
                     current_kind_in = id_kind;
                  end
               end else begin
                  stop_id = 1'b1;
               end
            end else if (b_ck != srpp_pkg::KIND_NONE) begin
               case (off)
                  srpp_pkg::OFF_X_LO,
                  srpp_pkg::OFF_Y_LO,
                  srpp_pkg::OFF_Z_LO: low_hold_in = data_byte;
                  srpp_pkg::OFF_X_HI: x_hold_in = word;
                  srpp_pkg::OFF_Y_HI: y_hold_in = word;
                  srpp_pkg::OFF_Z_HI: begin
                     kind_out        = b_ck;
                     updated_in      = 1'b1;
                     current_kind_in = srpp_pkg::KIND_NONE;
                     report_start_in = rs_sr;
                  end
                  default: ;
               endcase
            end

            pkt_end = stop_id || (idx_p1 == {1'b0, b_plen});
            if (pkt_end) begin
               parse_stopped_in = 1'b1;
            end
            if (pkt_end || kind_out != srpp_pkg::KIND_NONE) begin
               res_vld         = 1'b1;
               res.report_kind = kind_out;
               res.packet_end  = pkt_end;
               res.any_report  = pkt_end && updated_in;
               if (kind_out != srpp_pkg::KIND_NONE) begin
                  res.axis_x = x_hold_ff;
                  res.axis_y = y_hold_ff;
                  res.axis_z = word;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff    <= 8'd0;
         packet_length_ff <= 8'd0;
         report_start_ff  <= 8'd0;
         current_kind_ff  <= srpp_pkg::KIND_NONE;
         parse_stopped_ff <= 1'b1;
         updated_ff       <= 1'b0;
      end else begin
         byte_index_ff    <= byte_index_in;
         packet_length_ff <= packet_length_in;
         report_start_ff  <= report_start_in;
         current_kind_ff  <= current_kind_in;
         parse_stopped_ff <= parse_stopped_in;
         updated_ff       <= updated_in;
      end
   end

   always_ff @(posedge clock) begin
      low_hold_ff <= low_hold_in;
      x_hold_ff   <= x_hold_in;
      y_hold_ff   <= y_hold_in;
   end

endmodule

`default_nettype wire

FILE: sv/sensor_report_packet_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports   direction   payload
// req_      axis    in          tdata[7:0] data_byte, tuser[0] first_byte
// rsp_      axis    out         tdata x/y/z, tlast packet_end, tuser kind/any_report
// csr_      apb     in/out      four 8-bit id and channel registers at 0x0..0xc
//
// one request per clock sustained while rsp_tready is held high; a taken request passes through
// the input register, then the parse logic into the result register (output register)
// the parse state updates in the same cycle that moves a request into the output
// synchronous reset resets the control state and loads the configuration registers' defaults
// a stalled result holds the output register and, once the input register is full, req_tready

module sensor_report_packet_parser_unit #(
   parameter int unsigned MAX_PACKET_BYTES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic [0:0]  req_tuser,   // first_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // axis_x, axis_y, axis_z
   output logic [2:0]       rsp_tuser,   // report_kind[1:0], any_report
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   srpp_pkg::cfg_type    cfg;
   srpp_pkg::result_type res;
   srpp_pkg::result_type out_ff, out_in;
   logic                 res_vld;
   logic                 in_vld_ff, in_vld_in;
   logic [7:0]           in_data_ff, in_data_in;
   logic                 in_first_ff, in_first_in;
   logic                 out_vld_ff, out_vld_in;
   logic                 advance, step;

   srpp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srpp_core #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .data_byte  (in_data_ff),
      .first_byte (in_first_ff),
      .cfg        (cfg),
      .res_vld    (res_vld),
      .res        (res)
   );

   assign advance    = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_data_in  = in_data_ff;
      in_first_in = in_first_ff;
      if (req_tready) begin
         in_vld_in   = req_tvalid;
         in_data_in  = req_tdata;
         in_first_in = req_tuser[0];
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_in     = out_ff;
      if (advance) begin
         out_vld_in = step && res_vld;
         out_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      in_first_ff <= in_first_in;
      out_ff      <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.axis_z, out_ff.axis_y, out_ff.axis_x};
   assign rsp_tuser  = {out_ff.any_report, out_ff.report_kind};
   assign rsp_tlast  = out_ff.packet_end;

endmodule

`default_nettype wire

FILE: sv/srpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "sensor_report_packet_parser_unit_macros.svh"

module srpp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic [0:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast,
   input wire logic        csr_psel,
   input wire logic        csr_penable,
   input wire logic        csr_pwrite,
   input wire logic [3:0]  csr_paddr,
   input wire logic [31:0] csr_pwdata,
   input wire logic [31:0] csr_prdata,
   input wire logic        csr_pready
);

   // a stalled result keeps its payload
   `SRPP_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // a result without a report carries zero axes
   `SRPP_ASSERT(a_zero_axes, clock, reset, rsp_tvalid && rsp_tuser[1:0] == 2'd0 |-> rsp_tdata == 48'd0, "axes set without report")

   // only packet end reports any_report, and a mid packet result is a report
   `SRPP_ASSERT(a_mid_packet, clock, reset, rsp_tvalid && !rsp_tlast |-> !rsp_tuser[2] && rsp_tuser[1:0] != 2'd0, "bad mid packet result")

   // a packet end with a report implies any_report
   `SRPP_ASSERT(a_end_any, clock, reset, rsp_tvalid && rsp_tlast && rsp_tuser[1:0] != 2'd0 |-> rsp_tuser[2], "report not flagged at end")

   // no result right after reset
   `SRPP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result after reset")

endmodule

bind sensor_report_packet_parser_unit srpp_checker u_srpp_checker (.*);

`default_nettype wire
